// File: rtl/hhrc_pkg.sv
// Package for the hex header record checker: result status codes, result struct,
// frame size constant and the character/hex parsing helpers.
// No dependencies.
`default_nettype none

package hhrc_pkg;

  // Largest frame; a declared length must stay below this.
  localparam int unsigned MaxFrame = 1024;

  // Position counter saturates at its all-ones value.
  localparam int unsigned PosWidth = 12;
  localparam logic [PosWidth-1:0] PosMax = '1;

  // Header is five characters: two for the checksum, three for the length.
  localparam int unsigned HdrChars = 5;
  // Bytes 0..5 must be letters or digits; payload starts at position 5.
  localparam logic [PosWidth-1:0] AlnumSpan    = PosWidth'(6);
  localparam logic [PosWidth-1:0] PayloadStart = PosWidth'(5);
  localparam logic [11:0]         MinLength    = 12'd6;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoData   = 2'd1,
    StLenErr   = 2'd2,
    StMismatch = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [7:0]  declared_checksum;
    logic [7:0]  computed_checksum;
    logic [11:0] declared_length;
  } result_t;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // {valid, nibble} for one ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= "a" && c <= "f") begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= "A" && c <= "F") begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Parse two or three characters (three_chars selects) with optional 0x prefix,
  // stopping at the first non-hex character.
  function automatic logic [11:0] parse_hex(input logic [7:0] c0, input logic [7:0] c1,
                                            input logic [7:0] c2, input logic three_chars);
    logic [7:0]  chars [3];
    logic [11:0] val;
    logic        stop;
    logic        prefix;
    logic [4:0]  d;
    chars[0] = c0;
    chars[1] = c1;
    chars[2] = c2;
    val      = '0;
    stop     = 1'b0;
    prefix   = (c0 == "0") && (c1 == "x" || c1 == "X");
    for (int i = 0; i < 3; i++) begin
      d = hex_digit(chars[i]);
      if ((i >= 2 || !prefix) && (i < 2 || three_chars) && !stop) begin
        if (d[4]) begin
          val = {val[7:0], d[3:0]};
        end else begin
          stop = 1'b1;
        end
      end
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// File: rtl/hhrc_in_stage.sv
// Input register of the hex header record checker.
// Holds one byte transfer; uses nothing from hhrc_pkg, only plain logic.
`default_nettype none

module hhrc_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       advance_i,
  output logic            valid_o,
  output logic [7:0]      data_o,
  output logic            last_o
);

  logic       valid_q, valid_d;
  logic [7:0] data_q;
  logic       last_q;
  logic       accept;

  // Stall only while the held byte cannot move on this cycle.
  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

`default_nettype wire

// File: rtl/hhrc_frame.sv
// Frame state of the hex header record checker: position, header characters,
// running payload sum and the result computed on the last byte. Uses hhrc_pkg.
`default_nettype none

module hhrc_frame (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] data_i,
  input  wire logic       last_i,
  output hhrc_pkg::result_t result_o
);

  logic [hhrc_pkg::PosWidth-1:0] pos_q, pos_d;
  logic                          alnum_q, alnum_d;
  logic [7:0]                    sum_q, sum_d;
  logic                          zero_q, zero_d;
  logic [7:0]                    hc_q [hhrc_pkg::HdrChars];

  logic                          hdr_wr;
  logic [11:0]                   win_len;
  logic                          in_window;
  logic [7:0]                    hc_eff [hhrc_pkg::HdrChars];
  logic [11:0]                   fin_len;
  logic [11:0]                   fin_decl;
  logic [7:0]                    comp;

  assign hdr_wr = pos_q < hhrc_pkg::PosWidth'(hhrc_pkg::HdrChars);

  // Length used for the payload window; all header bytes are written by then.
  assign win_len   = hhrc_pkg::parse_hex(hc_q[2], hc_q[3], hc_q[4], 1'b1);
  assign in_window = (pos_q >= hhrc_pkg::PayloadStart) && (pos_q != hhrc_pkg::PosMax) &&
                     (pos_q < win_len) && !zero_q;

  // Running state for this byte.
  always_comb begin
    pos_d   = (pos_q == hhrc_pkg::PosMax) ? pos_q : pos_q + 1'b1;
    alnum_d = alnum_q;
    if (pos_q < hhrc_pkg::AlnumSpan && !hhrc_pkg::is_alnum(data_i)) begin
      alnum_d = 1'b0;
    end
    sum_d  = sum_q;
    zero_d = zero_q;
    if (in_window) begin
      if (data_i == 8'd0) begin
        zero_d = 1'b1;
      end else begin
        sum_d = sum_q + data_i;
      end
    end
  end

  // Header as seen at the end of this byte; unreceived characters read as zero.
  always_comb begin
    for (int i = 0; i < hhrc_pkg::HdrChars; i++) begin
      hc_eff[i] = hc_q[i];
      if (hdr_wr && pos_q == hhrc_pkg::PosWidth'(i)) begin
        hc_eff[i] = data_i;
      end
      if (hhrc_pkg::PosWidth'(i) >= pos_d) begin
        hc_eff[i] = 8'd0;
      end
    end
  end

  assign fin_len  = hhrc_pkg::parse_hex(hc_eff[2], hc_eff[3], hc_eff[4], 1'b1);
  assign fin_decl = hhrc_pkg::parse_hex(hc_eff[0], hc_eff[1], 8'd0, 1'b0);
  assign comp     = 8'd0 - sum_d;

  // Result with status priority: no data, then length, then checksum.
  always_comb begin
    result_o.declared_checksum = fin_decl[7:0];
    result_o.declared_length   = fin_len;
    result_o.computed_checksum = 8'd0;
    if (pos_d < hhrc_pkg::AlnumSpan || !alnum_d) begin
      result_o.status = hhrc_pkg::StNoData;
    end else if (fin_len < hhrc_pkg::MinLength ||
                 {1'b0, fin_len} >= 13'(hhrc_pkg::MaxFrame)) begin
      result_o.status = hhrc_pkg::StLenErr;
    end else begin
      result_o.computed_checksum = comp;
      result_o.status = (comp == fin_decl[7:0]) ? hhrc_pkg::StOk : hhrc_pkg::StMismatch;
    end
  end

  // Frame state; the last byte returns it to the start of a record.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      alnum_q <= 1'b1;
      sum_q   <= '0;
      zero_q  <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        pos_q   <= '0;
        alnum_q <= 1'b1;
        sum_q   <= '0;
        zero_q  <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        alnum_q <= alnum_d;
        sum_q   <= sum_d;
        zero_q  <= zero_d;
      end
    end
  end

  // Header characters, written once per record.
  always_ff @(posedge clk_i) begin
    if (step_i && hdr_wr) begin
      hc_q[pos_q[2:0]] <= data_i;
    end
  end

`ifndef SYNTH
  // A last byte always leaves the frame at its start.
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && last_i |=> pos_q == '0 && alnum_q && sum_q == '0 && !zero_q)
    else $error("frame state not cleared after last byte");

  // Position moves only with a byte transfer.
  a_pos_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_i |=> $stable(pos_q))
    else $error("position changed without a byte");
`endif

endmodule

`default_nettype wire

// File: rtl/hhrc_out_stage.sv
// Result register of the hex header record checker.
// Holds one result transfer toward the consumer. Uses hhrc_pkg.
`default_nettype none

module hhrc_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,
  input  wire hhrc_pkg::result_t result_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output hhrc_pkg::result_t      result_o
);

  logic              valid_q, valid_d;
  hhrc_pkg::result_t result_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

// File: rtl/hex_header_record_checker_core.sv
// Top level of the hex header record checker.
// Instantiates hhrc_in_stage, hhrc_frame and hhrc_out_stage; uses hhrc_pkg.
//
// Checks one ASCII record streamed one byte per transfer, the final byte flagged by
// last_byte_i. Characters 0..1 carry the checksum and 2..4 the length in hex (optional
// 0x prefix, parsing stops at the first non-hex character). One result transfer follows
// each record: status (ok, no data, length error, checksum mismatch), both parsed header
// values and, for a valid length, the two's complement of the payload byte sum up to the
// first zero byte (else zero). The block takes one byte every cycle unless a last byte
// waits for a busy result register. A byte is held in the input register while the frame
// logic updates the running state, and the result register loads as the last byte leaves
// the input register. The result register lets bytes of the next record flow in while a
// result waits; only a last byte waits for the result register to free up.
`default_nettype none

module hex_header_record_checker_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       status_o,
  output logic [7:0]       declared_checksum_o,
  output logic [7:0]       computed_checksum_o,
  output logic [11:0]      declared_length_o
);

  logic              byte_valid;
  logic [7:0]        byte_data;
  logic              byte_last;
  logic              advance;
  logic              out_free;
  hhrc_pkg::result_t frame_result;
  hhrc_pkg::result_t out_result;

  // A held byte moves on unless it ends a record and the result slot is busy.
  assign out_free = !out_valid_o || !out_stall_i;
  assign advance  = byte_valid && (!byte_last || out_free);

  hhrc_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .advance_i   (advance),
    .valid_o     (byte_valid),
    .data_o      (byte_data),
    .last_o      (byte_last)
  );

  hhrc_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .data_i   (byte_data),
    .last_i   (byte_last),
    .result_o (frame_result)
  );

  hhrc_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance && byte_last),
    .result_i    (frame_result),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign status_o            = out_result.status;
  assign declared_checksum_o = out_result.declared_checksum;
  assign computed_checksum_o = out_result.computed_checksum;
  assign declared_length_o   = out_result.declared_length;

`ifndef SYNTH
  // A result never overwrites one that is still stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> !(advance && byte_last))
    else $error("result overwritten while stalled");

  // A finished record shows a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && byte_last |=> out_valid_o)
    else $error("missing result after last byte");

  // Input stalls only behind a held last byte.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> byte_valid && byte_last && out_valid_o && out_stall_i)
    else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire
